FILE: rtl/bpmc_pkg.sv
`default_nettype none

package bpmc_pkg;

	// Field widths
	localparam int TIME_W   = 32;
	localparam int THRESH_W = 16;
	localparam int CHAN_W   = 2;
	localparam int PERIOD_W = 10;
	localparam int STEP_W   = 2;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 24;

	// Register indexes
	localparam logic CFG_LONG_PRESS      = 1'b0;
	localparam logic CFG_VERY_LONG_PRESS = 1'b1;

	// Reset values of the thresholds
	localparam logic [THRESH_W-1:0] LONG_PRESS_RST      = 16'd1000;
	localparam logic [THRESH_W-1:0] VERY_LONG_PRESS_RST = 16'd2500;

	typedef enum logic [1:0] {
		EV_NONE      = 2'd0,
		EV_SHORT     = 2'd1,
		EV_LONG      = 2'd2,
		EV_VERY_LONG = 2'd3
	} press_event_t;

	typedef enum logic [1:0] {
		MODE_OFF   = 2'd0,
		MODE_BLINK = 2'd1,
		MODE_WAVE  = 2'd2
	} display_mode_t;

	// One result beat, before packing
	typedef struct packed {
		logic [PERIOD_W-1:0] wave_period_ms;
		logic [CHAN_W-1:0]   lamp_channel_d;
		logic [CHAN_W-1:0]   lamp_channel_c;
		logic [CHAN_W-1:0]   lamp_channel_b;
		logic [CHAN_W-1:0]   lamp_channel_a;
		display_mode_t       display_mode;
		press_event_t        press_event;
	} result_t;

	// Wave period for each step of the cycle
	function automatic logic [PERIOD_W-1:0] wave_period(input logic [STEP_W-1:0] step);
		logic [PERIOD_W-1:0] p;
		case (step)
			2'd0:    p = 10'd1000;
			2'd1:    p = 10'd500;
			2'd2:    p = 10'd300;
			2'd3:    p = 10'd100;
			default: p = 10'd1000;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/button_press_mode_controller_core.sv
// An accepted input beat passes the input register and then the result register
// on its way to m_tdata. Throughput: one beat per cycle; the two registers form
// a two-entry pipeline that advances whenever the result is taken or empty.
// Reset (arst_n low, asynchronous): pipeline empty, thresholds 1000/2500 ms,
// button released, press start 0, mode off, channels 0..3, wave period 1000 ms.
`default_nettype none

module button_press_mode_controller_core (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire                                 cfg_index,
	input  wire  [bpmc_pkg::THRESH_W-1:0]       cfg_wdata,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	// [0] button_released, [32:1] time_ms, [39:33] zero
	input  wire  [bpmc_pkg::IN_DATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	// [1:0] press_event, [3:2] display_mode, [5:4] lamp_channel_a,
	// [7:6] lamp_channel_b, [9:8] lamp_channel_c, [11:10] lamp_channel_d,
	// [21:12] wave_period_ms, [23:22] zero
	output logic [bpmc_pkg::OUT_DATA_W-1:0]     m_tdata
);
	import bpmc_pkg::*;

	logic                valid_s1;
	logic                level_s1;
	logic [TIME_W-1:0]   time_s1;
	logic                out_valid_q;
	result_t             out_q;
	result_t             result;
	press_event_t        press_event;
	logic                out_free;
	logic                advance;

	assign out_free = ~out_valid_q | m_tready;
	assign advance  = valid_s1 & out_free;
	assign s_tready = ~valid_s1 | advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			level_s1 <= s_tdata[0];
			time_s1  <= s_tdata[TIME_W:1];
		end
	end

	bpmc_classify u_classify (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.advance         (advance),
		.button_released (level_s1),
		.time_ms         (time_s1),
		.press_event     (press_event)
	);

	bpmc_state u_state (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.press_event (press_event),
		.result      (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W-$bits(result_t)){1'b0}}, out_q};

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |=> out_valid_q && $stable(out_q))
		else $error("pending result beat lost");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled with an empty pipeline");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advancing beat did not reach the result register");

endmodule

`default_nettype wire

FILE: rtl/bpmc_classify.sv
`default_nettype none

module bpmc_classify (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire                                  cfg_index,
	input  wire  [bpmc_pkg::THRESH_W-1:0]        cfg_wdata,
	input  wire                                  advance,
	input  wire                                  button_released,
	input  wire  [bpmc_pkg::TIME_W-1:0]          time_ms,
	output bpmc_pkg::press_event_t               press_event
);
	import bpmc_pkg::*;

	logic [THRESH_W-1:0] long_press_q;
	logic [THRESH_W-1:0] very_long_press_q;
	logic                prev_level_q;
	logic [TIME_W-1:0]   press_start_q;
	logic [TIME_W-1:0]   elapsed;
	logic                falling;
	logic                rising;

	// Threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q      <= LONG_PRESS_RST;
			very_long_press_q <= VERY_LONG_PRESS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LONG_PRESS:      long_press_q      <= cfg_wdata;
				CFG_VERY_LONG_PRESS: very_long_press_q <= cfg_wdata;
				default:             long_press_q      <= long_press_q;
			endcase
		end
	end

	// Detect edges against the previous sample
	assign falling = prev_level_q & ~button_released;
	assign rising  = ~prev_level_q & button_released;
	assign elapsed = time_ms - press_start_q;

	// Track level and capture press start on the falling edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q  <= 1'b1;
			press_start_q <= '0;
		end else if (advance) begin
			prev_level_q <= button_released;
			if (falling) begin
				press_start_q <= time_ms;
			end
		end
	end

	// Classify the press on release, strict compares
	always_comb begin
		press_event = EV_NONE;
		if (rising) begin
			if (elapsed > {{(TIME_W-THRESH_W){1'b0}}, very_long_press_q}) begin
				press_event = EV_VERY_LONG;
			end else if (elapsed > {{(TIME_W-THRESH_W){1'b0}}, long_press_q}) begin
				press_event = EV_LONG;
			end else begin
				press_event = EV_SHORT;
			end
		end
	end

	a_press_start: assert property (@(posedge clk) disable iff (!arst_n)
		advance && falling |=> press_start_q == $past(time_ms))
		else $error("press start not captured on falling edge");

endmodule

`default_nettype wire

FILE: rtl/bpmc_state.sv
`default_nettype none

module bpmc_state (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     advance,
	input  wire bpmc_pkg::press_event_t press_event,
	output bpmc_pkg::result_t       result
);
	import bpmc_pkg::*;

	display_mode_t       mode_q;
	display_mode_t       mode_next;
	logic [CHAN_W-1:0]   chan_q [4];
	logic [CHAN_W-1:0]   chan_next [4];
	logic [STEP_W-1:0]   step_q;
	logic [STEP_W-1:0]   step_next;

	// Next mode, channels and wave step
	always_comb begin
		mode_next = mode_q;
		step_next = step_q;
		for (int k = 0; k < 4; k++) begin
			chan_next[k] = chan_q[k];
		end
		case (press_event)
			EV_LONG: begin
				case (mode_q)
					MODE_OFF:   mode_next = MODE_BLINK;
					MODE_BLINK: mode_next = MODE_WAVE;
					default:    mode_next = MODE_BLINK;
				endcase
			end
			EV_SHORT: begin
				case (mode_q)
					MODE_OFF: mode_next = mode_q;
					MODE_BLINK: begin
						for (int k = 0; k < 4; k++) begin
							chan_next[k] = chan_q[k] + 2'd1;
						end
					end
					default: step_next = step_q + 2'd1;
				endcase
			end
			default: mode_next = mode_q;
		endcase
	end

	// Commit on each advancing beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OFF;
			step_q <= '0;
			for (int k = 0; k < 4; k++) begin
				chan_q[k] <= CHAN_W'(k);
			end
		end else if (advance) begin
			mode_q <= mode_next;
			step_q <= step_next;
			for (int k = 0; k < 4; k++) begin
				chan_q[k] <= chan_next[k];
			end
		end
	end

	// Result shows the state after this sample
	always_comb begin
		result.press_event    = press_event;
		result.display_mode   = mode_next;
		result.lamp_channel_a = chan_next[0];
		result.lamp_channel_b = chan_next[1];
		result.lamp_channel_c = chan_next[2];
		result.lamp_channel_d = chan_next[3];
		result.wave_period_ms = wave_period(step_next);
	end

	a_very_long_keeps_mode: assert property (@(posedge clk) disable iff (!arst_n)
		advance && press_event == EV_VERY_LONG |=> $stable(mode_q) && $stable(step_q))
		else $error("very long press changed state");

	a_chan_rotation: assert property (@(posedge clk) disable iff (!arst_n)
		chan_q[1] == chan_q[0] + 2'd1 && chan_q[2] == chan_q[0] + 2'd2
		&& chan_q[3] == chan_q[0] + 2'd3)
		else $error("lamp channels lost their rotation order");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(mode_q) && $stable(step_q) && $stable(chan_q[0]))
		else $error("state changed without an advancing beat");

endmodule

`default_nettype wire

FILE: dv/button_press_mode_controller_core_test.sv
`default_nettype none

module button_press_mode_controller_core_test;
	import bpmc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	// Wave period per step, step 0 in the lowest slot
	localparam logic [3:0][PERIOD_W-1:0] PERIODS = {10'd100, 10'd300, 10'd500, 10'd1000};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic                  cfg_index;
	logic [THRESH_W-1:0]   cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	// Predicted controller state and thresholds
	logic                     last_level;
	logic [TIME_W-1:0]        press_start;
	display_mode_t            disp_mode;
	logic [3:0][CHAN_W-1:0]   chans;
	logic [STEP_W-1:0]        wave_step;
	logic [THRESH_W-1:0]      thr_long;
	logic [THRESH_W-1:0]      thr_very_long;

	// Panel states still to come out of the block, oldest first
	result_t panel_q[$];

	bit idle_on;
	int stall_left;
	int cycles;
	int samples_sent;
	int beats_seen;
	int bad_fields;
	int event_tally[4];

	button_press_mode_controller_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #6 clk = ~clk;

	// Advance the predicted controller by one button sample
	function automatic result_t classify_sample(input logic released, input logic [TIME_W-1:0] now);
		result_t r;
		logic [TIME_W-1:0] held;
		press_event_t ev;
		ev = EV_NONE;
		if (last_level && !released) begin
			press_start = now;
		end else if (!last_level && released) begin
			held = now - press_start;
			if (held > {16'd0, thr_very_long}) begin
				ev = EV_VERY_LONG;
			end else if (held > {16'd0, thr_long}) begin
				ev = EV_LONG;
				case (disp_mode)
					MODE_OFF:   disp_mode = MODE_BLINK;
					MODE_BLINK: disp_mode = MODE_WAVE;
					default:    disp_mode = MODE_BLINK;
				endcase
			end else begin
				ev = EV_SHORT;
				if (disp_mode == MODE_BLINK) begin
					for (int k = 0; k < 4; k++)
						chans[k] = chans[k] + 2'd1;
				end else if (disp_mode != MODE_OFF) begin
					wave_step = wave_step + 2'd1;
				end
			end
		end
		last_level = released;
		r.press_event    = ev;
		r.display_mode   = disp_mode;
		r.lamp_channel_a = chans[0];
		r.lamp_channel_b = chans[1];
		r.lamp_channel_c = chans[2];
		r.lamp_channel_d = chans[3];
		r.wave_period_ms = PERIODS[wave_step];
		return r;
	endfunction

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			bad_fields++;
			if (bad_fields <= 10)
				$display("mismatch on %s at beat %0d: expected %0d, got %0d",
					name, beats_seen, want, got);
		end
	endtask

	// Check each result beat against the oldest predicted panel state
	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata[21:0]);
			if (panel_q.size() == 0) begin
				bad_fields++;
				if (bad_fields <= 10)
					$display("unexpected result beat: %h", m_tdata);
			end else begin
				want = panel_q.pop_front();
				event_tally[want.press_event]++;
				compare_field("press_event", want.press_event, got.press_event);
				compare_field("display_mode", want.display_mode, got.display_mode);
				compare_field("lamp_channel_a", want.lamp_channel_a, got.lamp_channel_a);
				compare_field("lamp_channel_b", want.lamp_channel_b, got.lamp_channel_b);
				compare_field("lamp_channel_c", want.lamp_channel_c, got.lamp_channel_c);
				compare_field("lamp_channel_d", want.lamp_channel_d, got.lamp_channel_d);
				compare_field("wave_period_ms", want.wave_period_ms, got.wave_period_ms);
				compare_field("padding", 0, m_tdata[23:22]);
			end
			beats_seen++;
		end
	end

	// Stall the result side in random bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(1, 13) - 1;
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, panel_q.size());
			$display("status: fail");
			$finish;
		end
	end

	// Send one button sample, with an optional idle burst ahead of it
	task automatic send_sample(input logic released, input logic [TIME_W-1:0] now);
		result_t r;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, now, released};
		do @(posedge clk); while (!s_tready);
		r = classify_sample(released, now);
		panel_q.push_back(r);
		samples_sent++;
	endtask

	// Drop valid and wait until every result is out
	task automatic settle();
		s_tvalid <= 1'b0;
		while (panel_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_thresholds(input logic [THRESH_W-1:0] long_ms,
			input logic [THRESH_W-1:0] very_long_ms);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_LONG_PRESS;
		cfg_wdata <= long_ms;
		@(posedge clk);
		cfg_index <= CFG_VERY_LONG_PRESS;
		cfg_wdata <= very_long_ms;
		@(posedge clk);
		cfg_we        <= 1'b0;
		thr_long      = long_ms;
		thr_very_long = very_long_ms;
	endtask

	// Press at a random time, maybe hold for a few samples, release after held_ms
	task automatic press_release(input logic [TIME_W-1:0] held_ms);
		logic [TIME_W-1:0] t0;
		int holds;
		t0 = $urandom();
		holds = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
		send_sample(1'b0, t0);
		repeat (holds) send_sample(1'b0, t0 + $urandom());
		send_sample(1'b1, t0 + held_ms);
		if ($urandom_range(0, 4) == 0)
			send_sample(1'b1, $urandom());
	endtask

	// Press lengths clustered on both thresholds, plus wide and wrapping ones
	function automatic logic [TIME_W-1:0] pick_hold();
		logic [TIME_W-1:0] d;
		case ($urandom_range(0, 9))
			0:       d = 32'd0;
			1, 2:    d = {16'd0, thr_long} + $urandom_range(0, 2) - 1;
			3, 4:    d = {16'd0, thr_very_long} + $urandom_range(0, 2) - 1;
			5, 6:    d = $urandom_range(0, 3000);
			7:       d = $urandom_range(0, 65535);
			8:       d = $urandom();
			default: d = 32'hFFFF_FFFF - $urandom_range(0, 3);
		endcase
		return d;
	endfunction

	// Each event kind, threshold edges, mode steps off to blink to wave, wave period cycle, timestamp wrap
	task automatic test_directed();
		idle_on = 1'b1;
		send_sample(1'b1, 32'd0);
		send_sample(1'b0, 32'd100);
		send_sample(1'b1, 32'd300);
		send_sample(1'b0, 32'd1000);
		send_sample(1'b1, 32'd2001);
		send_sample(1'b0, 32'd5000);
		send_sample(1'b1, 32'd6000);
		send_sample(1'b0, 32'd7000);
		send_sample(1'b1, 32'd9500);
		repeat (4) begin
			send_sample(1'b0, 32'd20000);
			send_sample(1'b1, 32'd20000);
		end
		send_sample(1'b0, 32'd30000);
		send_sample(1'b0, 32'd31000);
		send_sample(1'b1, 32'd32501);
		send_sample(1'b0, 32'hFFFF_FF00);
		send_sample(1'b1, 32'h0000_0100);
		send_sample(1'b0, 32'hFFFF_FFFF);
		send_sample(1'b1, 32'hFFFF_FFFE);
		settle();
	endtask

	// Threshold settings including both extremes and crossed thresholds
	task automatic test_thresholds();
		logic [THRESH_W-1:0] lo [5];
		logic [THRESH_W-1:0] hi [5];
		lo = '{16'd0, 16'd65535, 16'd0, 16'd3000, 16'd1};
		hi = '{16'd0, 16'd65535, 16'd65535, 16'd2000, 16'd2};
		for (int s = 0; s < 5; s++) begin
			set_thresholds(lo[s], hi[s]);
			idle_on = ($urandom_range(0, 3) != 0);
			send_sample(1'b0, 32'd0);
			send_sample(1'b1, 32'd1);
			repeat (15) press_release(pick_hold());
			settle();
		end
		set_thresholds(LONG_PRESS_RST, VERY_LONG_PRESS_RST);
	endtask

	// Mostly press and release sequences, some random line noise
	task automatic test_random();
		for (int c = 0; c < 8; c++) begin
			idle_on = ($urandom_range(0, 3) != 0);
			repeat (30) begin
				if ($urandom_range(0, 6) == 0)
					send_sample(1'($urandom_range(0, 1)), $urandom());
				else
					press_release(pick_hold());
			end
		end
	endtask

	// Full rate on both sides
	task automatic test_back_to_back();
		idle_on = 1'b0;
		repeat (30) press_release(pick_hold());
		settle();
	endtask

	initial begin
		clk        = 1'b0;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = CFG_LONG_PRESS;
		cfg_wdata  = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		m_tready   = 1'b0;
		idle_on    = 1'b0;
		stall_left = 0;
		cycles     = 0;
		samples_sent = 0;
		beats_seen   = 0;
		bad_fields   = 0;
		event_tally  = '{0, 0, 0, 0};
		last_level    = 1'b1;
		press_start   = '0;
		disp_mode     = MODE_OFF;
		chans         = {2'd3, 2'd2, 2'd1, 2'd0};
		wave_step     = '0;
		thr_long      = LONG_PRESS_RST;
		thr_very_long = VERY_LONG_PRESS_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_thresholds();
		test_random();
		test_back_to_back();

		$display("%0d button samples sent, %0d result beats checked, %0d field mismatches",
			samples_sent, beats_seen, bad_fields);
		$display("events seen: none %0d, short %0d, long %0d, very long %0d",
			event_tally[0], event_tally[1], event_tally[2], event_tally[3]);
		if (bad_fields == 0 && panel_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: button_press_mode_controller_core.f
rtl/bpmc_pkg.sv
rtl/bpmc_classify.sv
rtl/bpmc_state.sv
rtl/button_press_mode_controller_core.sv
dv/button_press_mode_controller_core_test.sv
